FILE: sv/ezad_pkg.sv
`timescale 1ns / 1ps
// Package for the EMA z-score anomaly detector.
// Holds command and status types and fixed constants; depends on nothing.
package ezad_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int ALPHA_W     = 17;
	localparam int THRESH_W    = 15;
	localparam int Z_W         = 16;
	localparam int COUNT_W     = 4;
	localparam int PROD_W      = 49;
	localparam int SUM_W       = 50;
	localparam int VAR_W       = 64;
	localparam int ROOT_W      = 32;
	localparam int NUM_W       = 41;
	localparam int ITER_W      = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 17;
	localparam int SQRT_STEPS  = 32;
	localparam int DIV_STEPS   = 41;

	localparam logic [ALPHA_W-1:0]  ALPHA_ONE      = 17'h10000;
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET    = 17'd6554;
	localparam logic [THRESH_W-1:0] THRESH_RESET   = 15'd768;
	localparam logic [COUNT_W-1:0]  COUNT_MAX      = 4'd15;
	localparam logic [SUM_W-1:0]    ROUND_HALF     = 50'd32768;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

	typedef struct packed {
		logic load;
		logic mul_mean;
		logic upd_mean;
		logic dev;
		logic sqr;
		logic mul_vlo;
		logic mul_vhi;
		logic upd_var;
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic fin;
	} ezad_cmd_t;

	typedef struct packed {
		logic score_ok;
	} ezad_status_t;

endpackage

FILE: sv/ezad_sample_if.sv
`timescale 1ns / 1ps
// Request channel carrying one Q16.16 sample.
// Uses ezad_pkg for field widths.
interface ezad_sample_if
	import ezad_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

FILE: sv/ezad_score_if.sv
`timescale 1ns / 1ps
// Request channel carrying one z-score result.
// Uses ezad_pkg for field widths.
interface ezad_score_if
	import ezad_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic signed [Z_W-1:0] z_score;
	logic                  score_valid;
	logic                  anomaly_flag;

	modport source (output valid, output z_score, output score_valid, output anomaly_flag,
		input ready);
	modport sink (input valid, input z_score, input score_valid, input anomaly_flag,
		output ready);
endinterface

FILE: sv/ezad_datapath.sv
`timescale 1ns / 1ps
// Datapath: mean and variance recurrences, iterative square root and divider.
// Uses ezad_pkg; driven by commands from ezad_ctrl.
module ezad_datapath
	import ezad_pkg::*;
#(
	parameter int MIN_SAMPLES = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ezad_cmd_t             cmd,
	output ezad_status_t          status,
	input  logic [SAMPLE_W-1:0]   sample_value,
	input  logic [ALPHA_W-1:0]    smoothing_factor,
	input  logic [THRESH_W-1:0]   score_threshold,
	output logic signed [Z_W-1:0] z_score,
	output logic                  score_valid,
	output logic                  anomaly_flag
);

	logic [SAMPLE_W-1:0] x_q, mean_q, dev_q;
	logic [ALPHA_W-1:0]  a_q, b_q;
	logic                first_q, neg_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PROD_W-1:0]   pa_q, pb_q;
	logic [SUM_W-1:0]    lo_q, mean_sum, hi_sum;
	logic [VAR_W-1:0]    d2_q, var_q;
	logic [VAR_W-1:0]    rad_q;
	logic [ROOT_W+1:0]   rem_q, rem_sh, trial;
	logic [ROOT_W-1:0]   root_q;
	logic [NUM_W-1:0]    num_q, quo_q;
	logic [ROOT_W-1:0]   drem_q;
	logic [ROOT_W:0]     drem_sh;
	logic [Z_W:0]        mag;

	assign mean_sum = SUM_W'(pa_q) + SUM_W'(pb_q) + ROUND_HALF;
	assign hi_sum   = SUM_W'(pa_q) + SUM_W'(pb_q);
	assign rem_sh   = {rem_q[ROOT_W-1:0], rad_q[VAR_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign drem_sh  = {drem_q, num_q[NUM_W-1]};

	assign status.score_ok = (count_q >= COUNT_W'(MIN_SAMPLES)) && (var_q != '0);

	always_comb begin
		if (neg_q) begin
			mag = (quo_q > NUM_W'(32768)) ? 17'd32768 : quo_q[Z_W:0];
		end else begin
			mag = (quo_q > NUM_W'(32767)) ? 17'd32767 : quo_q[Z_W:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			var_q   <= '0;
		end else begin
			if (cmd.load) begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.upd_mean) begin
				mean_q <= first_q ? x_q : mean_sum[SAMPLE_W+15:16];
			end
			if (cmd.upd_var) begin
				var_q <= first_q ? '0
					: ({hi_sum[VAR_W-17:0], 16'h0000} + VAR_W'(lo_q[SUM_W-1:16]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= sample_value;
			a_q     <= (smoothing_factor > ALPHA_ONE) ? ALPHA_ONE : smoothing_factor;
			b_q     <= ALPHA_ONE - ((smoothing_factor > ALPHA_ONE) ? ALPHA_ONE
				: smoothing_factor);
			first_q <= (count_q == '0);
		end
		if (cmd.mul_mean) begin
			pa_q <= a_q * x_q;
			pb_q <= b_q * mean_q;
		end
		if (cmd.dev) begin
			neg_q <= x_q < mean_q;
			dev_q <= (x_q < mean_q) ? (mean_q - x_q) : (x_q - mean_q);
		end
		if (cmd.sqr) begin
			d2_q <= dev_q * dev_q;
		end
		if (cmd.mul_vlo) begin
			pa_q <= a_q * d2_q[31:0];
			pb_q <= b_q * var_q[31:0];
		end
		if (cmd.mul_vhi) begin
			lo_q <= mean_sum;
			pa_q <= a_q * d2_q[63:32];
			pb_q <= b_q * var_q[63:32];
		end
		if (cmd.sqrt_init) begin
			rad_q  <= var_q;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[VAR_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			num_q  <= {1'b0, dev_q, 8'h00} + NUM_W'(root_q[ROOT_W-1:1]);
			drem_q <= '0;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (drem_sh >= {1'b0, root_q}) begin
				drem_q <= ROOT_W'(drem_sh - {1'b0, root_q});
				quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				drem_q <= drem_sh[ROOT_W-1:0];
				quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			if (status.score_ok) begin
				z_score      <= neg_q ? Z_W'(17'h10000 - mag) : Z_W'(mag);
				score_valid  <= 1'b1;
				anomaly_flag <= mag > {2'b00, score_threshold};
			end else begin
				z_score      <= '0;
				score_valid  <= 1'b0;
				anomaly_flag <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/ezad_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing the datapath and both handshakes.
// Uses ezad_pkg command and status types.
module ezad_ctrl
	import ezad_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  ezad_status_t status,
	output ezad_cmd_t    cmd
);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_MMUL  = 13'b0000000000010,
		ST_MADD  = 13'b0000000000100,
		ST_DEV   = 13'b0000000001000,
		ST_SQR   = 13'b0000000010000,
		ST_VLO   = 13'b0000000100000,
		ST_VHI   = 13'b0000001000000,
		ST_VADD  = 13'b0000010000000,
		ST_CHK   = 13'b0000100000000,
		ST_SQRT  = 13'b0001000000000,
		ST_DINIT = 13'b0010000000000,
		ST_DIV   = 13'b0100000000000,
		ST_FIN   = 13'b1000000000000
	} state_t;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              ov_q, ov_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		ov_d    = ov_q && !out_ready;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MMUL;
				end
			end
			ST_MMUL: begin
				cmd.mul_mean = 1'b1;
				state_d      = ST_MADD;
			end
			ST_MADD: begin
				cmd.upd_mean = 1'b1;
				state_d      = ST_DEV;
			end
			ST_DEV: begin
				cmd.dev = 1'b1;
				state_d = ST_SQR;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				state_d = ST_VLO;
			end
			ST_VLO: begin
				cmd.mul_vlo = 1'b1;
				state_d     = ST_VHI;
			end
			ST_VHI: begin
				cmd.mul_vhi = 1'b1;
				state_d     = ST_VADD;
			end
			ST_VADD: begin
				cmd.upd_var = 1'b1;
				state_d     = ST_CHK;
			end
			ST_CHK: begin
				cmd.sqrt_init = 1'b1;
				iter_d        = ITER_W'(SQRT_STEPS - 1);
				state_d       = status.score_ok ? ST_SQRT : ST_FIN;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d        = iter_q - 1'b1;
				if (iter_q == '0) begin
					state_d = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				iter_d       = ITER_W'(DIV_STEPS - 1);
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q - 1'b1;
				if (iter_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!ov_q || out_ready) begin
					cmd.fin = 1'b1;
					ov_d    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
			ov_q    <= ov_d;
		end
	end

endmodule

FILE: sv/ema_zscore_anomaly_detector_top.sv
`timescale 1ns / 1ps
// Top level of the EMA z-score anomaly detector: configuration registers,
// controller and datapath. Depends on ezad_pkg, both channel interfaces and submodules.
//
// Usage: each request on the samples channel carries one unsigned Q16.16 sample
// and produces exactly one request on the scores channel (signed Q8.8 z-score,
// a score-valid bit and an anomaly flag). A sample is taken when valid and ready
// are high at a rising edge; ready is high whenever the engine is idle.
// When no score is formed (fewer than MIN_SAMPLES samples or zero variance), the
// square root and divider are skipped; otherwise the 32-step square root and the
// 41-step divider, which divides by the root, run one after the other. A new sample is
// taken only once the engine has returned to idle. The result sits in an output
// register, so a new sample is accepted while an earlier result waits; if the
// receiver still stalls when the next result is ready, the engine holds it and
// keeps ready low. Reset clears mean, variance and sample count and restores the
// register defaults (smoothing 6554, threshold 768). Configuration is written
// through cfg_we, cfg_index and cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module ema_zscore_anomaly_detector_top
	import ezad_pkg::*;
#(
	parameter int MIN_SAMPLES = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ezad_sample_if.sink           samples,
	ezad_score_if.source          scores
);

	logic [ALPHA_W-1:0]  smoothing_q;
	logic [THRESH_W-1:0] threshold_q;
	ezad_cmd_t           cmd;
	ezad_status_t        status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_q <= ALPHA_RESET;
			threshold_q <= THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMOOTHING: smoothing_q <= cfg_wdata;
				REG_THRESHOLD: threshold_q <= cfg_wdata[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ezad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (scores.valid),
		.out_ready (scores.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ezad_datapath #(
		.MIN_SAMPLES (MIN_SAMPLES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.sample_value     (samples.sample_value),
		.smoothing_factor (smoothing_q),
		.score_threshold  (threshold_q),
		.z_score          (scores.z_score),
		.score_valid      (scores.score_valid),
		.anomaly_flag     (scores.anomaly_flag)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for ema_zscore_anomaly_detector_top: a directed table, then random sample streams.
// Depends on ezad_pkg, ezad_sample_if, ezad_score_if and the top level.
// Each result is checked against a running mean/variance z-score predictor or typed row.
module testbench;
	import ezad_pkg::*;

	localparam int MIN_COUNT   = 10;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 100;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [Z_W-1:0] z;
		logic                  ok;
		logic                  flag;
	} score_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    index;
		logic [SAMPLE_W-1:0]     value;
		logic                    typed;
		score_t                  want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ezad_sample_if sample_bus ();
	ezad_score_if  score_bus ();

	ema_zscore_anomaly_detector_top #(.MIN_SAMPLES(MIN_COUNT)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples  (sample_bus.sink),
		.scores   (score_bus.source)
	);

	logic [ALPHA_W-1:0]  ema_alpha;
	logic [THRESH_W-1:0] ema_thresh;
	logic [31:0]         ema_mean;
	logic [63:0]         ema_var;
	logic [COUNT_W-1:0]  ema_count;

	score_t     expected_scores[$];
	logic       next_typed;
	score_t     next_want;
	idle_mode_t idle_mode;
	int         error_count;
	int         requests_sent;
	int         scores_seen;
	int         scored_count;
	int         flagged_count;
	int         quiet_cycles;
	row_t       directed[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitpos;
		root = '0;
		bitpos = 64'd1 << 62;
		while (bitpos > v)
			bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (v >= root + bitpos) begin
				v = v - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	// Advances the mean, variance and count by one sample and forms its z-score.
	function automatic score_t update_zscore(logic [SAMPLE_W-1:0] x);
		logic [ALPHA_W-1:0] a;
		logic [ALPHA_W-1:0] b;
		logic [49:0]        msum;
		logic [31:0]        dv;
		logic [63:0]        d2;
		logic [95:0]        vsum;
		logic [63:0]        sd;
		logic [63:0]        absdev;
		logic [63:0]        mag;
		logic               neg;
		score_t             r;
		a = (ema_alpha > ALPHA_ONE) ? ALPHA_ONE : ema_alpha;
		b = ALPHA_ONE - a;
		if (ema_count == 0) begin
			ema_mean = x;
			ema_var = '0;
		end else begin
			msum = 50'(a) * 50'(x) + 50'(b) * 50'(ema_mean) + 50'd32768;
			ema_mean = msum[47:16];
			dv = (x >= ema_mean) ? x - ema_mean : ema_mean - x;
			d2 = 64'(dv) * 64'(dv);
			vsum = 96'(a) * 96'(d2) + 96'(b) * 96'(ema_var) + 96'd32768;
			ema_var = vsum[79:16];
		end
		if (ema_count < COUNT_MAX)
			ema_count = ema_count + 1'b1;
		neg = x < ema_mean;
		absdev = neg ? 64'(ema_mean - x) : 64'(x - ema_mean);
		r.z = '0;
		r.ok = 1'b0;
		r.flag = 1'b0;
		if (ema_count >= MIN_COUNT && ema_var != 0) begin
			sd = floor_sqrt(ema_var);
			mag = (absdev * 256 + (sd >> 1)) / sd;
			if (neg && mag > 64'd32768)
				mag = 64'd32768;
			else if (!neg && mag > 64'd32767)
				mag = 64'd32767;
			r.z = neg ? 16'(-mag) : 16'(mag);
			r.ok = 1'b1;
			r.flag = mag > 64'(ema_thresh);
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on score %0d: %s got %0d, expected %0d", scores_seen, field, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		score_t s;
		if (arst_n && sample_bus.valid && sample_bus.ready) begin
			s = update_zscore(sample_bus.sample_value);
			expected_scores.insert(expected_scores.size(), next_typed ? next_want : s);
		end
	end

	always @(posedge clk) begin
		score_t w;
		if (arst_n && score_bus.valid && score_bus.ready) begin
			scores_seen++;
			if (expected_scores.size() == 0) begin
				$display("score %0d arrived with no request outstanding", scores_seen);
				error_count++;
			end else begin
				w = expected_scores.pop_front();
				if (score_bus.z_score !== w.z)
					report_mismatch("z_score", int'(score_bus.z_score), int'(w.z));
				if (score_bus.score_valid !== w.ok)
					report_mismatch("score_valid", int'(score_bus.score_valid), int'(w.ok));
				if (score_bus.anomaly_flag !== w.flag)
					report_mismatch("anomaly_flag", int'(score_bus.anomaly_flag),
						int'(w.flag));
				if (score_bus.score_valid === 1'b1)
					scored_count++;
				if (score_bus.anomaly_flag === 1'b1)
					flagged_count++;
			end
		end
	end

	always @(negedge clk) begin
		if (idle_mode == IDLE_RECEIVER)
			score_bus.ready = $urandom_range(99) >= 64;
		else if (idle_mode == IDLE_BOTH)
			score_bus.ready = $urandom_range(99) >= 15;
		else
			score_bus.ready = 1'b1;
	end

	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (score_bus.valid && score_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a request", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_sample(logic [SAMPLE_W-1:0] x, logic typed, score_t want);
		int gap;
		gap = 0;
		if (idle_mode == IDLE_SENDER)
			while ($urandom_range(99) < 64) gap++;
		else if (idle_mode == IDLE_BOTH)
			while ($urandom_range(99) < 15) gap++;
		if (gap > 0) begin
			sample_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_bus.valid = 1'b1;
		sample_bus.sample_value = x;
		next_typed = typed;
		next_want = want;
		do @(posedge clk); while (!sample_bus.ready);
		requests_sent++;
		@(negedge clk);
	endtask

	// Registers change only with nothing in flight.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		sample_bus.valid = 1'b0;
		while (expected_scores.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_SMOOTHING)
			ema_alpha = val;
		else
			ema_thresh = val[THRESH_W-1:0];
	endtask

	function automatic row_t srow(logic [31:0] x, logic typed);
		row_t r;
		r.kind = ROW_SAMPLE;
		r.index = '0;
		r.value = x;
		r.typed = typed;
		r.want = '{z: '0, ok: 1'b0, flag: 1'b0};
		return r;
	endfunction

	function automatic row_t crow(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		row_t r;
		r = srow(val, 1'b0);
		r.kind = ROW_CFG;
		r.index = idx;
		return r;
	endfunction

	function automatic void add_row(row_t r);
		directed.insert(directed.size(), r);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(logic [31:0] base, int spread);
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return base + ($urandom() >> spread) - ($urandom() >> spread);
		else if (roll < 85)
			return base + ($urandom() >> ($urandom_range(8)));
		return $urandom();
	endfunction

	initial begin
		score_t none;
		logic [31:0] base;
		int spread;
		none = '{z: '0, ok: 1'b0, flag: 1'b0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.sample_value = '0;
		score_bus.ready = 1'b0;
		idle_mode = IDLE_NONE;
		next_typed = 1'b0;
		next_want = none;
		error_count = 0;
		requests_sent = 0;
		scores_seen = 0;
		scored_count = 0;
		flagged_count = 0;
		quiet_cycles = 0;
		ema_alpha = ALPHA_RESET;
		ema_thresh = THRESH_RESET;
		ema_mean = '0;
		ema_var = '0;
		ema_count = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fewer than the minimum count gives a zero score whatever the sample.
		add_row(srow(32'hFFFF_FFFF, 1'b1));
		add_row(srow(32'h0000_0000, 1'b1));
		for (int i = 0; i < 7; i++)
			add_row(srow(32'h8000_0000 >> i, 1'b1));
		add_row(srow(32'h0001_0000, 1'b0));
		add_row(srow(32'hFFFF_FFFF, 1'b0));
		// With alpha at one the mean follows the sample and the variance drops to zero.
		add_row(crow(REG_SMOOTHING, 32'h10000));
		add_row(srow(32'h0000_0000, 1'b1));
		add_row(crow(REG_SMOOTHING, 32'h1FFFF));
		add_row(srow(32'h0000_0000, 1'b1));
		add_row(crow(REG_THRESHOLD, 32'd0));
		add_row(crow(REG_SMOOTHING, 32'd1));
		add_row(srow(32'hFFFF_FFFF, 1'b0));
		add_row(crow(REG_SMOOTHING, 32'h10000));
		add_row(srow(32'hFFFF_FFFF, 1'b1));
		add_row(crow(REG_SMOOTHING, 32'd1));
		add_row(srow(32'h0000_0000, 1'b0));
		add_row(crow(REG_THRESHOLD, 32'd32767));
		add_row(crow(REG_SMOOTHING, 32'd0));
		add_row(srow(32'h1234_5678, 1'b0));
		add_row(srow(32'hFFFF_FFFF, 1'b0));

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].index, directed[i].value[CFG_DATA_W-1:0]);
			else
				send_sample(directed[i].value, directed[i].typed, directed[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			idle_mode = idle_mode_t'(phase);
			for (int seg = 0; seg < 4; seg++) begin
				case ($urandom_range(7))
					0: write_reg(REG_SMOOTHING, 17'd0);
					1: write_reg(REG_SMOOTHING, ALPHA_ONE);
					2: write_reg(REG_SMOOTHING, 17'h1FFFF);
					3: write_reg(REG_SMOOTHING, CFG_DATA_W'($urandom_range(65535, 1)));
					default: write_reg(REG_SMOOTHING, CFG_DATA_W'($urandom_range(16384, 1)));
				endcase
				case ($urandom_range(4))
					0: write_reg(REG_THRESHOLD, 17'd0);
					1: write_reg(REG_THRESHOLD, 17'd32767);
					2: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(32767)));
					default: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(1024, 128)));
				endcase
				base = $urandom();
				spread = $urandom_range(31, 4);
				for (int n = 0; n < 78; n++) begin
					if ($urandom_range(99) < 8)
						spread = $urandom_range(31, 4);
					send_sample(pick_sample(base, spread), 1'b0, none);
				end
			end
		end
		sample_bus.valid = 1'b0;
		idle_mode = IDLE_NONE;

		while (expected_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_scores.size() != 0) begin
			$display("%0d scores never arrived", expected_scores.size());
			error_count++;
		end
		$display("Sent %0d samples over four idling phases; %0d scores, %0d formed, %0d flagged.",
			requests_sent, scores_seen, scored_count, flagged_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors", error_count);
			$display("FAIL");
		end
		$finish;
	end
endmodule
